@@ hw/rtl/syringe_homing_sequencer_unit_assert.svh @@
// Assertion macros shared by the syringe homing sequencer RTL.
`ifndef SYRINGE_HOMING_SEQUENCER_UNIT_ASSERT_SVH
`define SYRINGE_HOMING_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/shs_pkg.sv @@
// Package with the types and constants of the syringe homing sequencer.
package shs_pkg;

    // Field widths.
    localparam int VOL_W      = 20;
    localparam int DIVIDEND_W = 22;
    localparam int DIVISOR_W  = 21;
    localparam int QUOT_W     = 22;
    localparam int STEPS_W    = 12;

    // Sequencer constants.
    localparam logic [2:0]        DEBOUNCE_STEPS   = 3'd4;
    localparam logic [15:0]       HOMING_STEPS     = 16'd2100;
    localparam logic [QUOT_W-1:0] HOMING_THRESHOLD = 22'd2000;
    localparam logic [VOL_W-1:0]  MAX_VOLUME_NL    = 20'd1000000;
    localparam logic [VOL_W-1:0]  VPS_RESET        = 20'd500;
    localparam logic [2:0]        CNT_MAX          = 3'd7;

    // Operation codes.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_STEP  = 3'd2;
    localparam logic [2:0] OP_POLL  = 3'd3;
    localparam logic [2:0] OP_ARM   = 3'd4;

    // Reply codes.
    localparam logic [2:0] RPL_OK        = 3'd0;
    localparam logic [2:0] RPL_ERROR     = 3'd1;
    localparam logic [2:0] RPL_BUSY      = 3'd2;
    localparam logic [2:0] RPL_PARAM_ERR = 3'd3;
    localparam logic [2:0] RPL_NONE      = 3'd4;

    // Motor commands.
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_FWD       = 3'd1;
    localparam logic [2:0] CMD_BWD       = 3'd2;
    localparam logic [2:0] CMD_IMM_STOP  = 3'd3;
    localparam logic [2:0] CMD_REQ_STOP  = 3'd4;

    // Move results.
    localparam logic [2:0] RES_FINISHED    = 3'd0;
    localparam logic [2:0] RES_STOPPED     = 3'd1;
    localparam logic [2:0] RES_DRIVER_ERR  = 3'd2;
    localparam logic [2:0] RES_FAILED      = 3'd3;
    localparam logic [2:0] RES_NOT_REACHED = 3'd4;
    localparam logic [2:0] RES_NOT_LEFT    = 3'd5;

    // Syringe states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EXTRACT   = 3'd1;
    localparam logic [2:0] ST_DRAIN     = 3'd2;
    localparam logic [2:0] ST_TO_SENSOR = 3'd3;
    localparam logic [2:0] ST_TO_ZERO   = 3'd4;

    // One input item.
    typedef struct packed {
        logic [2:0]       operation;
        logic             direction;
        logic [VOL_W-1:0] volume_nl;
        logic             use_default_profile;
        logic             sensor_blocked;
        logic             motor_idle;
        logic             motor_fault;
        logic             motor_start_ok;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]         reply_code;
        logic [2:0]         motor_command;
        logic [STEPS_W-1:0] motor_steps;
        logic               motor_default_profile;
        logic               driver_check;
        logic               event_valid;
        logic [2:0]         move_result;
        logic [2:0]         syringe_state;
    } t_out_item;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hw/rtl/shs_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
`include "syringe_homing_sequencer_unit_assert.svh"

module shs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  shs_pkg::t_div_req i_req,
    output shs_pkg::t_div_rsp o_rsp
);
    import shs_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic                 r_run;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [QUOT_W-1:0]    r_q;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;

    logic [DIVISOR_W:0]   rem_sh;
    logic                 fits;
    logic [DIVISOR_W:0]   diff;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        rem_sh = {r_rem, r_q[QUOT_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
        diff   = rem_sh - {1'b0, r_div};
    end

    // Control: run flag, iteration counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(QUOT_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_run) begin
            r_q   <= {r_q[QUOT_W-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    `SHS_ASSERT_NOW(a_run_has_count, i_clk, i_rst_n, r_run, r_cnt != '0)
    `SHS_ASSERT_NOW(a_no_restart, i_clk, i_rst_n, i_req.start, !r_run)
    `SHS_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_run && r_cnt == CNT_W'(1), r_done)

endmodule

@@ hw/rtl/shs_seq.sv @@
// Command sequencer: state machine, step debounce and result register.
`include "syringe_homing_sequencer_unit_assert.svh"

module shs_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  shs_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output shs_pkg::t_out_item              o_out_item,
    input  logic [shs_pkg::VOL_W-1:0]       i_vol_per_step,
    output shs_pkg::t_div_req               o_div_req,
    input  shs_pkg::t_div_rsp               i_div_rsp,
    output logic [2:0]                      o_seq_state
);
    import shs_pkg::*;

    logic [2:0] r_seq, n_seq;
    logic [2:0] r_cnt, n_cnt;
    logic       r_stop, n_stop;
    logic       r_phase, n_phase;
    logic       r_armed, n_armed;
    logic       r_busy, n_busy;
    logic       r_dir, n_dir;
    logic       r_dflt, n_dflt;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_item, n_out_item;

    logic       accept;
    logic       load_out;
    logic       launch;
    logic       vol_bad;
    logic       fin;
    logic [2:0] fin_res;
    logic       hit;
    logic [2:0] cnt_inc;
    logic       blk_active;

    // Input is held while the divider runs or a result still waits.
    assign o_in_stall = r_busy | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;
    assign vol_bad    = (i_in_item.volume_nl == '0) || (i_in_item.volume_nl > MAX_VOLUME_NL);
    assign launch     = accept && i_in_item.operation == OP_START && !vol_bad
                        && r_seq == ST_IDLE && i_in_item.motor_start_ok;

    // Divider launch with rounding: (2v + f) / (2f).
    assign o_div_req.start    = launch;
    assign o_div_req.dividend = {1'b0, i_in_item.volume_nl, 1'b0} + {2'b00, i_vol_per_step};
    assign o_div_req.divisor  = {i_vol_per_step, 1'b0};

    // Debounce helpers for a step item.
    always_comb begin
        blk_active = (r_seq == ST_DRAIN) || (r_seq == ST_TO_SENSOR)
                     || (r_seq == ST_TO_ZERO && !r_phase);
        hit        = (r_seq == ST_TO_ZERO) ? !i_in_item.sensor_blocked
                                           : i_in_item.sensor_blocked;
        cnt_inc    = (r_cnt < CNT_MAX) ? r_cnt + 3'd1 : r_cnt;
    end

    // Next state and result of the item at hand.
    always_comb begin
        n_seq      = r_seq;
        n_cnt      = r_cnt;
        n_stop     = r_stop;
        n_phase    = r_phase;
        n_armed    = r_armed;
        n_busy     = r_busy;
        n_dir      = r_dir;
        n_dflt     = r_dflt;
        load_out   = 1'b0;
        fin        = 1'b0;
        fin_res    = RES_FINISHED;
        n_out_item = '0;
        n_out_item.reply_code = RPL_NONE;

        if (r_busy) begin
            // Step count is ready: issue the start.
            if (i_div_rsp.done) begin
                n_busy   = 1'b0;
                load_out = 1'b1;
                n_out_item.reply_code            = RPL_OK;
                n_out_item.motor_default_profile = r_dflt;
                if (!r_dir) begin
                    n_out_item.motor_command = CMD_FWD;
                    n_out_item.motor_steps   = (|i_div_rsp.quotient[QUOT_W-1:STEPS_W])
                        ? {STEPS_W{1'b1}} : i_div_rsp.quotient[STEPS_W-1:0];
                    n_seq = ST_EXTRACT;
                end else begin
                    n_out_item.motor_command = CMD_BWD;
                    if (i_div_rsp.quotient >= HOMING_THRESHOLD) begin
                        n_out_item.motor_steps = HOMING_STEPS[STEPS_W-1:0];
                        n_seq = ST_TO_SENSOR;
                    end else begin
                        n_out_item.motor_steps = i_div_rsp.quotient[STEPS_W-1:0];
                        n_seq = ST_DRAIN;
                    end
                end
                n_phase = 1'b1;
                n_stop  = 1'b0;
            end
        end else if (accept) begin
            load_out = 1'b1;
            unique case (i_in_item.operation)
                OP_START: begin
                    if (vol_bad) begin
                        n_out_item.reply_code = RPL_PARAM_ERR;
                    end else if (r_seq != ST_IDLE) begin
                        n_out_item.reply_code = RPL_BUSY;
                    end else begin
                        n_cnt = '0;
                        if (!i_in_item.motor_start_ok) begin
                            n_out_item.reply_code = RPL_ERROR;
                        end else begin
                            // Result follows when the divider is done.
                            load_out = 1'b0;
                            n_busy   = 1'b1;
                            n_dir    = i_in_item.direction;
                            n_dflt   = i_in_item.use_default_profile;
                        end
                    end
                end
                OP_STOP: begin
                    if (r_seq != ST_IDLE) begin
                        n_stop = 1'b1;
                        n_out_item.motor_command = CMD_REQ_STOP;
                        n_out_item.reply_code    = RPL_OK;
                    end else begin
                        n_out_item.reply_code = RPL_ERROR;
                    end
                end
                OP_STEP: begin
                    if (blk_active) begin
                        if (hit) begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= DEBOUNCE_STEPS) begin
                                if (r_seq == ST_DRAIN) begin
                                    n_seq = ST_TO_SENSOR;
                                end
                                n_out_item.motor_command = CMD_IMM_STOP;
                            end
                        end else begin
                            n_cnt = '0;
                        end
                    end
                    if ((blk_active || r_seq == ST_EXTRACT) && i_in_item.motor_fault) begin
                        n_out_item.motor_command = CMD_IMM_STOP;
                    end
                end
                OP_POLL: begin
                    if (r_seq == ST_EXTRACT || r_seq == ST_DRAIN) begin
                        fin     = i_in_item.motor_idle;
                        fin_res = r_stop ? RES_STOPPED
                                : (i_in_item.motor_fault ? RES_DRIVER_ERR : RES_FINISHED);
                    end else if (r_seq == ST_TO_SENSOR) begin
                        if (i_in_item.motor_idle) begin
                            if (r_stop) begin
                                fin = 1'b1; fin_res = RES_STOPPED;
                            end else if (i_in_item.motor_fault) begin
                                fin = 1'b1; fin_res = RES_DRIVER_ERR;
                            end else if (!i_in_item.sensor_blocked) begin
                                fin = 1'b1; fin_res = RES_NOT_REACHED;
                            end else begin
                                n_seq   = ST_TO_ZERO;
                                n_phase = 1'b1;
                            end
                        end
                    end else if (r_seq == ST_TO_ZERO) begin
                        if (r_phase) begin
                            // First tick of the move back to zero issues its start.
                            n_phase = 1'b0;
                            if (!i_in_item.motor_start_ok) begin
                                fin = 1'b1; fin_res = RES_FAILED;
                            end else begin
                                n_out_item.motor_command         = CMD_FWD;
                                n_out_item.motor_steps           = HOMING_STEPS[STEPS_W-1:0];
                                n_out_item.motor_default_profile = 1'b1;
                            end
                        end else if (i_in_item.motor_idle) begin
                            fin = 1'b1;
                            if (r_stop) begin
                                fin_res = RES_STOPPED;
                            end else if (i_in_item.motor_fault) begin
                                fin_res = RES_DRIVER_ERR;
                            end else if (i_in_item.sensor_blocked) begin
                                fin_res = RES_NOT_LEFT;
                            end else begin
                                fin_res = RES_FINISHED;
                            end
                        end
                    end
                end
                OP_ARM: begin
                    n_armed = 1'b1;
                    n_out_item.reply_code = RPL_OK;
                end
                default: begin
                    n_out_item.reply_code = RPL_NONE;
                end
            endcase
        end

        // End of a sequence: report and return to idle.
        if (fin) begin
            n_out_item.driver_check = (fin_res != RES_FINISHED) && (fin_res != RES_STOPPED);
            if (r_armed) begin
                n_out_item.event_valid = 1'b1;
                n_out_item.move_result = fin_res;
            end
            n_armed = 1'b0;
            n_seq   = ST_IDLE;
            n_phase = 1'b1;
        end

        n_out_item.syringe_state = n_seq;
        n_out_valid = load_out | (r_out_valid & i_out_stall);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ST_IDLE;
            r_cnt       <= '0;
            r_stop      <= 1'b0;
            r_phase     <= 1'b0;
            r_armed     <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_cnt       <= n_cnt;
            r_stop      <= n_stop;
            r_phase     <= n_phase;
            r_armed     <= n_armed;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dir  <= n_dir;
        r_dflt <= n_dflt;
        if (load_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_seq_state = r_seq;

    `SHS_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, r_busy, o_in_stall)
    `SHS_ASSERT_NOW(a_done_when_busy, i_clk, i_rst_n, i_div_rsp.done, r_busy)
    `SHS_ASSERT_NEXT(a_launch_busy, i_clk, i_rst_n, launch, r_busy && !r_out_valid)

endmodule

@@ hw/rtl/syringe_homing_sequencer_unit.sv @@
// Top level of the syringe homing sequencer: calibration register and unit wiring.
//
//  Channel   Signals                          Moves
//  --------  -------------------------------  ---------------------------------
//  in        i_in_valid, o_in_stall, i_in_item  one command or motor event item
//  out       o_out_valid, i_out_stall, o_out_item one result item per input item
//  config    i_cfg_we, i_cfg_data             volume per step in nanolitres
//
// A start item that passes its checks runs the serial divider, one quotient bit per
// cycle; its result goes to the output register once the divider is done.
// Every other item gives its result in the output register the cycle after acceptance.
// Reset is synchronous and active low; the calibration register resets to 500.
// The input stalls while the divider runs or while a result waits under an output stall.
`include "syringe_homing_sequencer_unit_assert.svh"

module syringe_homing_sequencer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  shs_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output shs_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic [shs_pkg::VOL_W-1:0] i_cfg_data
);
    import shs_pkg::*;

    logic [VOL_W-1:0] r_vps;
    logic [2:0]       seq_state;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    // Calibration register: zero and writes outside idle are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vps <= VPS_RESET;
        end else if (i_cfg_we && i_cfg_data != '0 && seq_state == ST_IDLE) begin
            r_vps <= i_cfg_data;
        end
    end

    shs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item),
        .i_vol_per_step (r_vps),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_seq_state    (seq_state)
    );

    shs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    `SHS_ASSERT_NOW(a_vps_nonzero, i_clk, i_rst_n, 1'b1, r_vps != '0)
    `SHS_ASSERT_NEXT(a_vps_held_busy, i_clk, i_rst_n, seq_state != ST_IDLE, $stable(r_vps))
    `SHS_ASSERT_NOW(a_div_when_idle, i_clk, i_rst_n, div_req.start, seq_state == ST_IDLE)

endmodule
